FILE: rtl/jsu_pkg.sv
// ---------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers for the JSON string unescaper.
// ---------------------------------------------------------------------------
package jsu_pkg;

  // decoder phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  // result kinds
  localparam logic [1:0] K_BYTE = 2'd0;
  localparam logic [1:0] K_DONE = 2'd1;
  localparam logic [1:0] K_ERR  = 2'd2;

  // error codes
  localparam logic [3:0] E_NONE      = 4'd0;
  localparam logic [3:0] E_QUOTE     = 4'd1;
  localparam logic [3:0] E_CTRL      = 4'd2;
  localparam logic [3:0] E_INC_ESC   = 4'd3;
  localparam logic [3:0] E_INC_HEX   = 4'd4;
  localparam logic [3:0] E_BAD_HEX   = 4'd5;
  localparam logic [3:0] E_SURROGATE = 4'd6;
  localparam logic [3:0] E_BAD_ESC   = 4'd7;
  localparam logic [3:0] E_UNTERM    = 4'd8;

  // input modes
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_LO_T  = 8'h74;
  localparam logic [7:0] CH_LO_U  = 8'h75;

  // one result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [3:0] err;
    logic       last;
  } res_t;

  // everything one input item produces
  typedef struct packed {
    res_t [2:0] res;
    logic [1:0] cnt;
  } dec_out_t;

  // hex digit decode: bit 4 is the valid flag
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] value,
                                  input logic [3:0] err, input logic last);
    res_t r;
    r.kind  = kind;
    r.value = value;
    r.err   = err;
    r.last  = last;
    return r;
  endfunction

endpackage

FILE: rtl/jsu_in_stage.sv
// ---------------------------------------------------------------------------
// jsu_in_stage
// Input register: holds one accepted transaction until the decoder takes it.
// ---------------------------------------------------------------------------
module jsu_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_mode,
  input  logic       take,
  output logic       valid,
  output logic       mode,
  output logic [7:0] data
);

  logic       valid_r, valid_nxt;
  logic       mode_r;
  logic [7:0] data_r;
  logic       load;

  // free when empty or when the held item moves on this cycle
  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      mode_r <= in_mode;
      data_r <= in_tdata;
    end
  end

  assign valid = valid_r;
  assign mode  = mode_r;
  assign data  = data_r;

endmodule

FILE: rtl/jsu_decode.sv
// ---------------------------------------------------------------------------
// jsu_decode
// Unescape state machine: turns one byte into zero to three result items.
// ---------------------------------------------------------------------------
module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       mode,
  input  logic [7:0] data,
  output dec_out_t   dout
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic        bad_r, bad_nxt;

  logic [4:0]  dig;
  logic [15:0] cp_sh;
  logic        bad_sh;
  logic        surr;
  logic        is_ws;
  logic        esc_ok;
  logic [7:0]  esc_val;

  // shared decode terms
  assign dig    = hex_digit(data);
  assign cp_sh  = {cp_r[11:0], (dig[4] ? dig[3:0] : 4'd0)};
  assign bad_sh = bad_r || !dig[4];
  assign surr   = (cp_sh[15:11] == 5'b11011);
  assign is_ws  = (data == CH_SPACE) || (data == CH_TAB) ||
                  (data == CH_CR) || (data == CH_LF);

  // simple escape letters
  always_comb begin
    esc_ok  = 1'b1;
    esc_val = data;
    case (data)
      CH_QUOTE: esc_val = CH_QUOTE;
      CH_BSL:   esc_val = CH_BSL;
      CH_SLASH: esc_val = CH_SLASH;
      CH_LO_B:  esc_val = CH_BS;
      CH_LO_F:  esc_val = CH_FF;
      CH_LO_N:  esc_val = CH_LF;
      CH_LO_R:  esc_val = CH_CR;
      CH_LO_T:  esc_val = CH_TAB;
      default:  esc_ok  = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    cp_nxt    = cp_r;
    bad_nxt   = bad_r;
    if (mode == MODE_END) begin
      phase_nxt = PH_IDLE;
      hcnt_nxt  = 2'd0;
      cp_nxt    = 16'd0;
      bad_nxt   = 1'b0;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (data == CH_QUOTE) begin
            phase_nxt = PH_STR;
          end else if (!is_ws) begin
            phase_nxt = PH_DONE;
          end
        end
        PH_STR: begin
          if (data == CH_QUOTE || data < CH_SPACE) begin
            phase_nxt = PH_DONE;
          end else if (data == CH_BSL) begin
            phase_nxt = PH_ESC;
          end
        end
        PH_ESC: begin
          if (data == CH_LO_U) begin
            phase_nxt = PH_HEX;
            hcnt_nxt  = 2'd0;
            cp_nxt    = 16'd0;
            bad_nxt   = 1'b0;
          end else if (esc_ok) begin
            phase_nxt = PH_STR;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_HEX: begin
          if (hcnt_r != 2'd3) begin
            hcnt_nxt = hcnt_r + 2'd1;
            cp_nxt   = cp_sh;
            bad_nxt  = bad_sh;
          end else begin
            phase_nxt = (bad_sh || surr) ? PH_DONE : PH_STR;
            hcnt_nxt  = 2'd0;
            cp_nxt    = 16'd0;
            bad_nxt   = 1'b0;
          end
        end
        PH_DONE: phase_nxt = PH_DONE;
        default: phase_nxt = PH_DONE;
      endcase
    end
  end

  // result items
  always_comb begin
    dout.res[0] = mk_res(K_BYTE, 8'd0, E_NONE, 1'b1);
    dout.res[1] = mk_res(K_BYTE, 8'd0, E_NONE, 1'b0);
    dout.res[2] = mk_res(K_BYTE, 8'd0, E_NONE, 1'b0);
    dout.cnt    = 2'd0;
    if (mode == MODE_END) begin
      dout.cnt = (phase_r == PH_DONE) ? 2'd0 : 2'd1;
      unique case (phase_r)
        PH_IDLE: dout.res[0] = mk_res(K_ERR, 8'd0, E_QUOTE, 1'b1);
        PH_STR:  dout.res[0] = mk_res(K_ERR, 8'd0, E_UNTERM, 1'b1);
        PH_ESC:  dout.res[0] = mk_res(K_ERR, 8'd0, E_INC_ESC, 1'b1);
        PH_HEX:  dout.res[0] = mk_res(K_ERR, 8'd0, E_INC_HEX, 1'b1);
        default: dout.cnt    = 2'd0;
      endcase
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (data != CH_QUOTE && !is_ws) begin
            dout.cnt    = 2'd1;
            dout.res[0] = mk_res(K_ERR, 8'd0, E_QUOTE, 1'b1);
          end
        end
        PH_STR: begin
          dout.cnt = 2'd1;
          if (data == CH_QUOTE) begin
            dout.res[0] = mk_res(K_DONE, 8'd0, E_NONE, 1'b1);
          end else if (data < CH_SPACE) begin
            dout.res[0] = mk_res(K_ERR, 8'd0, E_CTRL, 1'b1);
          end else if (data == CH_BSL) begin
            dout.cnt = 2'd0;
          end else begin
            dout.res[0] = mk_res(K_BYTE, data, E_NONE, 1'b1);
          end
        end
        PH_ESC: begin
          if (data != CH_LO_U) begin
            dout.cnt = 2'd1;
            if (esc_ok) begin
              dout.res[0] = mk_res(K_BYTE, esc_val, E_NONE, 1'b1);
            end else begin
              dout.res[0] = mk_res(K_ERR, 8'd0, E_BAD_ESC, 1'b1);
            end
          end
        end
        PH_HEX: begin
          if (hcnt_r == 2'd3) begin
            if (bad_sh) begin
              dout.cnt    = 2'd1;
              dout.res[0] = mk_res(K_ERR, 8'd0, E_BAD_HEX, 1'b1);
            end else if (surr) begin
              dout.cnt    = 2'd1;
              dout.res[0] = mk_res(K_ERR, 8'd0, E_SURROGATE, 1'b1);
            end else if (cp_sh[15:7] == 9'd0) begin
              // one byte
              dout.cnt    = 2'd1;
              dout.res[0] = mk_res(K_BYTE, {1'b0, cp_sh[6:0]}, E_NONE, 1'b1);
            end else if (cp_sh[15:11] == 5'd0) begin
              // two bytes
              dout.cnt    = 2'd2;
              dout.res[0] = mk_res(K_BYTE, {3'b110, cp_sh[10:6]}, E_NONE, 1'b0);
              dout.res[1] = mk_res(K_BYTE, {2'b10, cp_sh[5:0]}, E_NONE, 1'b1);
            end else begin
              // three bytes
              dout.cnt    = 2'd3;
              dout.res[0] = mk_res(K_BYTE, {4'b1110, cp_sh[15:12]}, E_NONE, 1'b0);
              dout.res[1] = mk_res(K_BYTE, {2'b10, cp_sh[11:6]}, E_NONE, 1'b0);
              dout.res[2] = mk_res(K_BYTE, {2'b10, cp_sh[5:0]}, E_NONE, 1'b1);
            end
          end
        end
        default: dout.cnt = 2'd0;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hcnt_r  <= 2'd0;
      cp_r    <= 16'd0;
      bad_r   <= 1'b0;
    end else if (en) begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      cp_r    <= cp_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

FILE: rtl/jsu_out_buf.sv
// ---------------------------------------------------------------------------
// jsu_out_buf
// Result register: holds up to three result items and shifts them out.
// ---------------------------------------------------------------------------
module jsu_out_buf
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  dec_out_t    din,
  output logic        room,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  res_t [2:0] ent_r, ent_nxt;
  logic [1:0] rem_r, rem_nxt;
  logic       fire;

  assign fire = out_tvalid && out_tready;
  // new item may load once the last pending result leaves
  assign room = (rem_r == 2'd0) || (rem_r == 2'd1 && out_tready);

  always_comb begin
    ent_nxt = ent_r;
    rem_nxt = rem_r;
    if (load) begin
      ent_nxt = din.res;
      rem_nxt = din.cnt;
    end else if (fire) begin
      ent_nxt[0] = ent_r[1];
      ent_nxt[1] = ent_r[2];
      rem_nxt    = rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  // head of the queue drives the port
  assign out_tvalid = (rem_r != 2'd0);
  assign out_tdata  = {4'd0, ent_r[0].err, ent_r[0].value};
  assign out_tuser  = ent_r[0].kind;
  assign out_tlast  = ent_r[0].last;

endmodule

FILE: rtl/json_string_unescape_utf8.sv
// Path: an accepted input is held in the input register, then decoded into the result register.
// Throughput: one input byte per cycle while the result register has room; an item giving n
// results holds the result register until all n have left (up to 3 for a \u escape with 3 UTF-8 bytes).
// Reset: synchronous, active low; clears the decoder phase to idle, the hex
// digit state, and both stage valid flags.
// ---------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming JSON string unescaper with UTF-8 encoding of \u escapes.
// ---------------------------------------------------------------------------
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] value, [11:8] error_code, [15:12] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  logic       st_valid;
  logic       st_mode;
  logic [7:0] st_data;
  logic       room;
  logic       adv;
  dec_out_t   dout;

  // item moves through the decoder when the result register can take it
  assign adv = st_valid && room;

  jsu_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_mode   (in_tuser[0]),
    .take      (adv),
    .valid     (st_valid),
    .mode      (st_mode),
    .data      (st_data)
  );

  jsu_decode u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .mode  (st_mode),
    .data  (st_data),
    .dout  (dout)
  );

  jsu_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .din        (dout),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: dv/unescape_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unescape_scoreboard_pkg
// Tracks the decoder state for every accepted input byte, queues the decoded
// bytes, completions and errors it should produce, and checks each result.
// ---------------------------------------------------------------------------
package unescape_scoreboard_pkg;
  import jsu_pkg::*;

  // code point limits for surrogates and the utf-8 length classes
  localparam logic [15:0] SURR_LO      = 16'hD800;
  localparam logic [15:0] SURR_HI      = 16'hDFFF;
  localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;

  // utf-8 lead and continuation prefixes
  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] CONT_BYTE  = 8'h80;

  // hex digit value of an ascii byte; returns 0 for a non-digit
  function automatic bit hex_nibble(input logic [7:0] b, output logic [3:0] v);
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b[3:0];
      return 1'b1;
    end
    if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      v = b[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  class unescape_scoreboard;
    phase_t      phase;
    logic [1:0]  digits_seen;
    logic [15:0] code_acc;
    bit          bad_digit;
    res_t        step_results[$];
    res_t        pending_results[$];
    int          mismatches;

    function new();
      phase = PH_IDLE;
      clear_escape();
      mismatches = 0;
    endfunction

    function void clear_escape();
      digits_seen = 2'd0;
      code_acc    = 16'd0;
      bad_digit   = 1'b0;
    endfunction

    function void add(logic [1:0] kind, logic [7:0] value, logic [3:0] err);
      res_t r;
      r.kind  = kind;
      r.value = value;
      r.err   = err;
      r.last  = 1'b0;
      step_results.push_back(r);
    endfunction

    // an error closes the string; data is ignored until the end marker
    function void raise_error(logic [3:0] err);
      add(K_ERR, 8'd0, err);
      phase = PH_DONE;
      clear_escape();
    endfunction

    // advance the decoder by one accepted byte; returns 0 if it was ignored
    function bit decode_byte(logic mode, logic [7:0] b);
      logic [3:0] nib;
      bit         effective;
      step_results.delete();
      effective = !(mode == MODE_DATA && phase == PH_DONE);
      if (mode == MODE_END) begin
        case (phase)
          PH_IDLE: add(K_ERR, 8'd0, E_QUOTE);
          PH_STR:  add(K_ERR, 8'd0, E_UNTERM);
          PH_ESC:  add(K_ERR, 8'd0, E_INC_ESC);
          PH_HEX:  add(K_ERR, 8'd0, E_INC_HEX);
          default: ;
        endcase
        phase = PH_IDLE;
        clear_escape();
      end else begin
        case (phase)
          PH_IDLE: begin
            if (b == CH_QUOTE) begin
              phase = PH_STR;
            end else if (!(b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)) begin
              raise_error(E_QUOTE);
            end
          end
          PH_STR: begin
            if (b == CH_QUOTE) begin
              add(K_DONE, 8'd0, E_NONE);
              phase = PH_DONE;
            end else if (b < CH_SPACE) begin
              raise_error(E_CTRL);
            end else if (b == CH_BSL) begin
              phase = PH_ESC;
            end else begin
              add(K_BYTE, b, E_NONE);
            end
          end
          PH_ESC: begin
            phase = PH_STR;
            case (b) inside
              CH_QUOTE, CH_BSL, CH_SLASH: add(K_BYTE, b, E_NONE);
              CH_LO_B: add(K_BYTE, CH_BS, E_NONE);
              CH_LO_F: add(K_BYTE, CH_FF, E_NONE);
              CH_LO_N: add(K_BYTE, CH_LF, E_NONE);
              CH_LO_R: add(K_BYTE, CH_CR, E_NONE);
              CH_LO_T: add(K_BYTE, CH_TAB, E_NONE);
              CH_LO_U: begin
                clear_escape();
                phase = PH_HEX;
              end
              default: raise_error(E_BAD_ESC);
            endcase
          end
          PH_HEX: begin
            // a non-digit still takes a digit position, as zero
            if (!hex_nibble(b, nib)) begin
              bad_digit = 1'b1;
            end
            code_acc = {code_acc[11:0], nib};
            if (digits_seen != 2'd3) begin
              digits_seen = digits_seen + 2'd1;
            end else if (bad_digit) begin
              raise_error(E_BAD_HEX);
            end else if (code_acc >= SURR_LO && code_acc <= SURR_HI) begin
              raise_error(E_SURROGATE);
            end else begin
              // utf-8 encoding of the code point
              if (code_acc <= ONE_BYTE_MAX) begin
                add(K_BYTE, code_acc[7:0], E_NONE);
              end else if (code_acc <= TWO_BYTE_MAX) begin
                add(K_BYTE, LEAD_TWO | {3'b000, code_acc[10:6]}, E_NONE);
                add(K_BYTE, CONT_BYTE | {2'b00, code_acc[5:0]}, E_NONE);
              end else begin
                add(K_BYTE, LEAD_THREE | {4'b0000, code_acc[15:12]}, E_NONE);
                add(K_BYTE, CONT_BYTE | {2'b00, code_acc[11:6]}, E_NONE);
                add(K_BYTE, CONT_BYTE | {2'b00, code_acc[5:0]}, E_NONE);
              end
              clear_escape();
              phase = PH_STR;
            end
          end
          default: ;
        endcase
      end
      // the final result of this byte carries last
      if (step_results.size() > 0) begin
        step_results[step_results.size() - 1].last = 1'b1;
      end
      foreach (step_results[i]) begin
        pending_results.push_back(step_results[i]);
      end
      return effective;
    endfunction

    // compare one output transaction against the oldest expected result
    function void check_result(logic [1:0] kind, logic [7:0] value, logic [3:0] err,
                               logic last);
      res_t exp;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d value 0x%02h error_code %0d last %0d",
               kind, value, err, last);
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      if (kind !== exp.kind) begin
        $error("kind: expected %0d, actual %0d", exp.kind, kind);
        mismatches++;
      end
      if (value !== exp.value) begin
        $error("value: expected 0x%02h, actual 0x%02h", exp.value, value);
        mismatches++;
      end
      if (err !== exp.err) begin
        $error("error_code: expected %0d, actual %0d", exp.err, err);
        mismatches++;
      end
      if (last !== exp.last) begin
        $error("last: expected %0d, actual %0d", exp.last, last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives json_string_unescape_utf8 with directed byte sequences and random
// strings (well-formed, truncated and garbled), with random gaps on both
// sides and one long output stall, and checks every result transaction.
// ---------------------------------------------------------------------------
module testbench;
  import jsu_pkg::*;
  import unescape_scoreboard_pkg::*;

  localparam int RANDOM_ITEMS = 300;
  localparam int HOLD_AFTER   = 100;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_LO_A = 8'h61;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'd0;
  logic [0:0]  in_tuser   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  unescape_scoreboard sb = new();

  int cycle_count   = 0;
  int items_done    = 0;
  int in_calm       = 0;
  int out_calm      = 0;
  bit long_hold_req = 1'b0;

  json_string_unescape_utf8 i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             sb.pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // check every output transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata[7:0], out_tdata[11:8], out_tlast);
    end
  end

  // idle cycles before the next transaction, with runs of back-to-back ones
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  task automatic send_item(input logic mode, input logic [7:0] b);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    if (sb.decode_byte(mode, b)) begin
      items_done++;
    end
    @(negedge clk);
  endtask

  task automatic send_end();
    send_item(MODE_END, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + 8'(d);
    end
    return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(d - 4'd10);
  endfunction

  // letters of the escapes; index 8 is the \u introducer
  function automatic logic [7:0] escape_letter(input int idx);
    case (idx)
      0:       return CH_QUOTE;
      1:       return CH_BSL;
      2:       return CH_SLASH;
      3:       return CH_LO_B;
      4:       return CH_LO_F;
      5:       return CH_LO_N;
      6:       return CH_LO_R;
      7:       return CH_LO_T;
      default: return CH_LO_U;
    endcase
  endfunction

  function automatic logic [15:0] random_code_point();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1, 2:    return 16'($urandom_range(16'h0001, 16'h007F));
      3, 4:    return 16'($urandom_range(16'h0080, 16'h07FF));
      5, 6, 7: return 16'($urandom_range(16'h0800, 16'hD7FF));
      8:       return 16'($urandom_range(16'hD800, 16'hDFFF));
      default: return 16'($urandom_range(16'hE000, 16'hFFFF));
    endcase
  endfunction

  // \uXXXX, optionally with one digit replaced by a non-digit
  task automatic send_unicode(input logic [15:0] cp, input bit corrupt);
    int         bad_pos;
    logic [7:0] c;
    logic [3:0] unused_nib;
    bad_pos = corrupt ? $urandom_range(0, 3) : -1;
    send_item(MODE_DATA, CH_BSL);
    send_item(MODE_DATA, CH_LO_U);
    for (int i = 0; i < 4; i++) begin
      c = hex_char(cp[4 * (3 - i) +: 4]);
      if (i == bad_pos) begin
        if ($urandom_range(0, 3) == 0) begin
          c = CH_QUOTE;
        end else begin
          do c = 8'($urandom_range(0, 255)); while (hex_nibble(c, unused_nib));
        end
      end
      send_item(MODE_DATA, c);
    end
  endtask

  // one element of a string body
  task automatic send_piece();
    int         pick;
    bit         is_escape;
    logic [7:0] c;
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      do c = 8'($urandom_range(CH_SPACE, 255)); while (c == CH_QUOTE || c == CH_BSL);
      send_item(MODE_DATA, c);
    end else if (pick < 14) begin
      send_item(MODE_DATA, CH_BSL);
      send_item(MODE_DATA, escape_letter($urandom_range(0, 7)));
    end else if (pick < 18) begin
      send_unicode(random_code_point(), 1'b0);
    end else if (pick == 18) begin
      send_unicode(random_code_point(), 1'b1);
    end else if ($urandom_range(0, 1) == 0) begin
      send_item(MODE_DATA, 8'($urandom_range(0, CH_SPACE - 1)));
    end else begin
      // unknown escape letter
      do begin
        c = 8'($urandom_range(0, 255));
        is_escape = 1'b0;
        for (int k = 0; k <= 8; k++) begin
          if (c == escape_letter(k)) begin
            is_escape = 1'b1;
          end
        end
      end while (is_escape);
      send_item(MODE_DATA, CH_BSL);
      send_item(MODE_DATA, c);
    end
  endtask

  // quoted string, sometimes cut off by the end marker
  task automatic send_string();
    int cut;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       send_item(MODE_DATA, CH_SPACE);
        1:       send_item(MODE_DATA, CH_TAB);
        2:       send_item(MODE_DATA, CH_CR);
        default: send_item(MODE_DATA, CH_LF);
      endcase
    end
    send_item(MODE_DATA, CH_QUOTE);
    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : -1;
    repeat ($urandom_range(0, 6)) send_piece();
    if (cut == 1) begin
      send_item(MODE_DATA, CH_BSL);
    end else if (cut == 2) begin
      send_item(MODE_DATA, CH_BSL);
      send_item(MODE_DATA, CH_LO_U);
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 1) == 0) begin
          send_item(MODE_DATA, hex_char(4'($urandom_range(0, 15))));
        end else begin
          send_item(MODE_DATA, 8'($urandom_range(0, 255)));
        end
      end
    end else if (cut < 0) begin
      send_item(MODE_DATA, CH_QUOTE);
      // trailing bytes after completion are ignored
      repeat ($urandom_range(0, 2)) send_item(MODE_DATA, 8'($urandom_range(0, 255)));
    end
    send_end();
  endtask

  // receiver: random stalls and one long hold-off
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      stall = draw_gap(out_calm);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    int random_start;
    bit hold_issued;
    hold_issued = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: whitespace, raw high byte, 3-byte \uFFFF, simple escape,
    // control byte, junk before the quote, end marker in every phase
    send_item(MODE_DATA, CH_TAB);
    send_item(MODE_DATA, CH_QUOTE);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, CH_BSL);
    send_item(MODE_DATA, CH_LO_U);
    send_item(MODE_DATA, 8'h46);
    send_item(MODE_DATA, 8'h66);
    send_item(MODE_DATA, 8'h46);
    send_item(MODE_DATA, 8'h66);
    send_item(MODE_DATA, CH_BSL);
    send_item(MODE_DATA, CH_LO_N);
    send_item(MODE_DATA, 8'h1F);
    send_item(MODE_END, 8'h00);
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_END, 8'hFF);
    send_item(MODE_END, 8'h00);
    send_item(MODE_DATA, CH_QUOTE);
    send_item(MODE_DATA, CH_BSL);
    send_item(MODE_END, 8'h00);
    send_item(MODE_DATA, CH_QUOTE);
    send_item(MODE_DATA, CH_BSL);
    send_item(MODE_DATA, CH_LO_U);
    send_item(MODE_END, 8'h00);
    send_item(MODE_DATA, CH_QUOTE);
    send_item(MODE_END, 8'h00);

    // random strings and noise
    random_start = items_done;
    while (items_done - random_start < RANDOM_ITEMS) begin
      if (!hold_issued && items_done - random_start >= HOLD_AFTER) begin
        hold_issued   = 1'b1;
        long_hold_req = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) begin
        send_string();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(($urandom_range(0, 3) == 0) ? MODE_END : MODE_DATA,
                    8'($urandom_range(0, 255)));
        end
        send_end();
      end
    end
    in_tvalid = 1'b0;

    // drain
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
